>>> src/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants and functions of the byte stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } item_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [255:0] initial_hash();
    return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  endfunction

endpackage

>>> src/sha256_queue.sv
// ----------------------------------------------------------------------------
// SHA-256 item queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module sha256_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sha256_pkg::item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output sha256_pkg::item_t   out_item
);

  localparam int unsigned Aw = $clog2(sha256_pkg::QueueDepth);

  sha256_pkg::item_t mem [sha256_pkg::QueueDepth];
  logic [Aw-1:0] wr_ptr;
  logic [Aw-1:0] rd_ptr;
  logic [Aw:0]   count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != (Aw+1)'(sha256_pkg::QueueDepth));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Aw'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Aw'(1);
      end
      if (push && !pop) begin
        count <= count + (Aw+1)'(1);
      end else if (pop && !push) begin
        count <= count - (Aw+1)'(1);
      end
    end
  end

endmodule

>>> src/sha256_core.sv
// ----------------------------------------------------------------------------
// SHA-256 core
// Buffers bytes, pads, compresses one round per cycle and emits the digest.
// ----------------------------------------------------------------------------
module sha256_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sha256_pkg::item_t in_item,
  output logic [31:0]       digest_word,
  output logic              last_word,
  output logic              out_valid,
  input  logic              out_ready
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_ROUND = 6'b000100,
    S_ADD   = 6'b001000,
    S_PAD   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;
  logic [7:0]   buffer [64];
  logic [5:0]   buf_rd;
  logic [7:0]   buf_q;
  logic [60:0]  byte_count;
  logic [63:0]  bits;
  logic [255:0] hash;
  logic [255:0] v;
  logic [31:0]  w [16];
  logic [5:0]   round;
  logic [6:0]   load_cnt;
  logic         finishing;
  logic         final_block;
  logic [5:0]   pad_pos;
  logic [2:0]   emit_idx;

  logic         buf_we;
  logic [5:0]   buf_wa;
  logic [7:0]   buf_wd;

  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] wt, s0w, s1w, wnew, t1, t2;

  assign {a, b, c, d, e, f, g, h} = v;
  assign s0w  = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
  assign s1w  = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]}
              ^ (w[14] >> 10);
  assign wnew = s1w + w[9] + s0w + w[0];
  assign wt   = w[0];
  assign t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
            + ((e & f) ^ (~e & g)) + sha256_pkg::round_k(round) + wt;
  assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
            + ((a & b) ^ (a & c) ^ (b & c));

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_EMIT);
  assign digest_word = hash[255 - 32*emit_idx -: 32];
  assign last_word   = (emit_idx == 3'd7);
  assign bits        = {byte_count, 3'b000};

  always_comb begin
    buf_we = 1'b0;
    buf_wa = byte_count[5:0];
    buf_wd = in_item.data_byte;
    if (state == S_IDLE && in_valid) begin
      buf_we = 1'b1;
      buf_wd = in_item.func ? 8'h80 : in_item.data_byte;
    end else if (state == S_PAD) begin
      buf_we = 1'b1;
      buf_wa = pad_pos;
      if (final_block && pad_pos >= 6'd56) begin
        buf_wd = bits[63 - 8*(pad_pos - 6'd56) -: 8];
      end else begin
        buf_wd = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buffer[buf_wa] <= buf_wd;
    end
    buf_q <= buffer[buf_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      hash        <= sha256_pkg::initial_hash();
      byte_count  <= '0;
      finishing   <= 1'b0;
      final_block <= 1'b0;
      emit_idx    <= '0;
      buf_rd      <= '0;
      load_cnt    <= '0;
      round       <= '0;
      pad_pos     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (!in_item.func) begin
              byte_count <= byte_count + 61'd1;
              if (byte_count[5:0] == 6'd63) begin
                finishing <= 1'b0;
                buf_rd    <= '0;
                load_cnt  <= '0;
                state     <= S_LOAD;
              end
            end else begin
              finishing   <= 1'b1;
              final_block <= (byte_count[5:0] < 6'd56);
              pad_pos     <= byte_count[5:0] + 6'd1;
              if (byte_count[5:0] == 6'd63) begin
                buf_rd   <= '0;
                load_cnt <= '0;
                state    <= S_LOAD;
              end else begin
                state <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          pad_pos <= pad_pos + 6'd1;
          if (pad_pos == 6'd63) begin
            buf_rd   <= '0;
            load_cnt <= '0;
            state    <= S_LOAD;
          end
        end
        S_LOAD: begin
          buf_rd   <= buf_rd + 6'd1;
          load_cnt <= load_cnt + 7'd1;
          if (load_cnt != 7'd0) begin
            w[15]     <= {w[15][23:0], buf_q};
            for (int i = 0; i < 15; i++) begin
              if (load_cnt[1:0] == 2'd1) begin
                w[i] <= w[i+1];
              end
            end
          end
          if (load_cnt == 7'd64) begin
            v     <= hash;
            round <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          v <= {t1 + t2, a, b, c, d + t1, e, f, g};
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= wnew;
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash[32*i +: 32] <= hash[32*i +: 32] + v[32*i +: 32];
          end
          if (!finishing) begin
            state <= S_IDLE;
          end else if (!final_block) begin
            final_block <= 1'b1;
            pad_pos     <= '0;
            state       <= S_PAD;
          end else begin
            emit_idx <= '0;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              hash       <= sha256_pkg::initial_hash();
              byte_count <= '0;
              finishing  <= 1'b0;
              state      <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/sha256_byte_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Each byte is buffered; the 64th byte of a block starts the block's load
// and compression, paced by the one-round-per-cycle compressor and the
// one-byte read port of the block buffer. A finish item pads one byte per
// cycle, compresses one or two blocks, then transfers eight digest words.
// A four-entry queue decouples the input from the core.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic        last_word
);

  sha256_pkg::item_t q_in;
  sha256_pkg::item_t q_out;
  logic q_valid;
  logic q_ready;

  assign q_in.func      = func;
  assign q_in.data_byte = data_byte;

  sha256_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (q_in),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_out)
  );

  sha256_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_ready    (q_ready),
    .in_item     (q_out),
    .digest_word (digest_word),
    .last_word   (last_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

endmodule
